// ===== rtl/z80pd_pkg.sv =====
// Package: shared types, codes and opcode tables of the Z80 predecoder.
`timescale 1ns / 1ps
`default_nettype none
package z80pd_pkg;

	localparam logic [2:0] PK_NONE = 3'd0;
	localparam logic [2:0] PK_CB   = 3'd1;
	localparam logic [2:0] PK_DD   = 3'd2;
	localparam logic [2:0] PK_ED   = 3'd3;
	localparam logic [2:0] PK_FD   = 3'd4;

	localparam logic [2:0] F_IMPL  = 3'd0;
	localparam logic [2:0] F_IMM8  = 3'd1;
	localparam logic [2:0] F_REL8  = 3'd2;
	localparam logic [2:0] F_PORT  = 3'd3;
	localparam logic [2:0] F_IMM16 = 3'd4;
	localparam logic [2:0] F_MEM16 = 3'd5;
	localparam logic [2:0] F_DISP  = 3'd6;
	localparam logic [2:0] F_DIMM  = 3'd7;

	localparam logic [7:0] OP_CB = 8'hCB;
	localparam logic [7:0] OP_DD = 8'hDD;
	localparam logic [7:0] OP_ED = 8'hED;
	localparam logic [7:0] OP_FD = 8'hFD;

	typedef struct packed {
		logic [7:0]  code_byte;
		logic [15:0] byte_address;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  prefix_kind;
		logic [7:0]  opcode;
		logic [2:0]  length;
		logic [2:0]  operand_form;
		logic [7:0]  first_operand;
		logic [7:0]  second_operand;
		logic [15:0] branch_target;
		logic        invalid;
		logic [15:0] start_address;
		logic        last_of_run;
	} out_item_t;

	// length/form code: len in [5:3], form in [2:0], zero = invalid
	typedef struct packed {
		logic        is_prefix;
		logic [2:0]  pk;
		logic [2:0]  len;
		logic [2:0]  form;
	} dec_t;

	function automatic dec_t enc(input logic [2:0] len, input logic [2:0] form);
		dec_t d;
		d = '0;
		d.len = len;
		d.form = form;
		return d;
	endfunction

	function automatic dec_t decode_main(input logic [7:0] op);
		dec_t d;
		d = enc(3'd1, F_IMPL);
		if (op < 8'h40) begin
			case (op[2:0])
				3'd1: d = op[3] ? enc(3'd1, F_IMPL) : enc(3'd3, F_IMM16);
				3'd2: if (op[5]) d = enc(3'd3, F_MEM16);
				3'd6: d = enc(3'd2, F_IMM8);
				3'd0: if (op[5:3] >= 3'd2) d = enc(3'd2, F_REL8);
				default: ;
			endcase
		end else if (op >= 8'hC0) begin
			case (op[2:0])
				3'd2: d = enc(3'd3, F_IMM16);
				3'd4: d = enc(3'd3, F_IMM16);
				3'd6: d = enc(3'd2, F_IMM8);
				3'd3: begin
					if (op == 8'hC3) d = enc(3'd3, F_IMM16);
					else if (op == 8'hD3 || op == 8'hDB) d = enc(3'd2, F_PORT);
				end
				3'd5: if (op == 8'hCD) d = enc(3'd3, F_IMM16);
				default: ;
			endcase
			d.is_prefix = (op == OP_CB) || (op == OP_DD) || (op == OP_ED) || (op == OP_FD);
			d.pk = (op == OP_CB) ? PK_CB : (op == OP_DD) ? PK_DD :
				(op == OP_ED) ? PK_ED : PK_FD;
		end
		return d;
	endfunction

	function automatic dec_t decode_ext(input logic [2:0] pk, input logic [7:0] op);
		dec_t d;
		d = '0;
		case (pk)
			PK_CB: if (op[7:3] != 5'b00110) d = enc(3'd2, F_IMPL);
			PK_ED: begin
				if (op[7:6] == 2'b01) begin
					if (op[2:0] == 3'd3) begin
						if (op[5:3] != 3'd4 && op[5:3] != 3'd5)
							d = enc(3'd4, F_MEM16);
					end else if (op[2:0] <= 3'd2) begin
						if (op[5:3] != 3'd6 || op[2:1] == 2'b01)
							d = enc(3'd2, F_IMPL);
					end else if (op[2:0] == 3'd7) begin
						if (op[5:3] <= 3'd5) d = enc(3'd2, F_IMPL);
					end else if (op[2:0] == 3'd4) begin
						if (op[5:3] == 3'd0) d = enc(3'd2, F_IMPL);
					end else if (op[2:0] == 3'd5) begin
						if (op[5:3] <= 3'd1) d = enc(3'd2, F_IMPL);
					end else begin
						if (op[5:3] == 3'd0 || op[5:3] == 3'd2 || op[5:3] == 3'd3)
							d = enc(3'd2, F_IMPL);
					end
				end else if ((op & 8'hE4) == 8'hA0) begin
					d = enc(3'd2, F_IMPL);
				end
			end
			PK_DD, PK_FD: begin
				case (op)
					8'h09, 8'h19, 8'h29, 8'h39, 8'h23, 8'h2B,
					8'hE1, 8'hE3, 8'hE5, 8'hE9, 8'hF9: d = enc(3'd2, F_IMPL);
					8'h21: d = enc(3'd4, F_IMM16);
					8'h22, 8'h2A: d = enc(3'd4, F_MEM16);
					8'h34, 8'h35: d = enc(3'd3, F_DISP);
					8'h36: d = enc(3'd4, F_DIMM);
					8'hCB: d = enc(3'd4, F_DISP);
					default: begin
						if (op != 8'h76 && ((op[7:3] == 5'b01110) ||
							(op >= 8'h40 && op <= 8'hBF && op[2:0] == 3'd6)))
							d = enc(3'd3, F_DISP);
					end
				endcase
			end
			default: ;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] prefix_byte(input logic [2:0] pk);
		case (pk)
			PK_CB: return OP_CB;
			PK_DD: return OP_DD;
			PK_ED: return OP_ED;
			PK_FD: return OP_FD;
			default: return 8'h00;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/z80pd_front.sv =====
// Front end: tracks prefixes and operands, builds one transaction per result.
`timescale 1ns / 1ps
`default_nettype none
module z80pd_front (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire z80pd_pkg::in_item_t in_data,
	input  wire                    in_fire,
	output z80pd_pkg::out_item_t   res0,
	output z80pd_pkg::out_item_t   res1,
	output logic [1:0]             res_count
);
	logic [1:0]  pos_q;
	logic [2:0]  pfx_q;
	logic [7:0]  opc_q;
	logic [7:0]  opnd_q [2];
	logic [15:0] start_q;
	logic [2:0]  rem_q;

	logic [1:0]  pos_d;
	logic [2:0]  pfx_d;
	logic [7:0]  opc_d;
	logic [15:0] start_d;
	logic [2:0]  rem_d;
	logic        wr_en;
	logic        wr_idx;
	logic        done;
	logic [7:0]  a0, a1v;
	z80pd_pkg::dec_t dm, dx, dd;
	z80pd_pkg::out_item_t inv_item, done_item;
	logic        fresh;

	always_comb begin
		dm = z80pd_pkg::decode_main(in_data.code_byte);
		dx = z80pd_pkg::decode_ext(pfx_q, in_data.code_byte);
		pos_d = pos_q; pfx_d = pfx_q; opc_d = opc_q; start_d = start_q; rem_d = rem_q;
		wr_en = 1'b0; wr_idx = 1'b0; done = 1'b0; fresh = 1'b0;
		a0 = opnd_q[0]; a1v = opnd_q[1];
		res_count = 2'd0;
		dd = '0;
		inv_item = '0;
		inv_item.prefix_kind = pfx_q;
		inv_item.opcode = z80pd_pkg::prefix_byte(pfx_q);
		inv_item.length = 3'd1;
		inv_item.invalid = 1'b1;
		inv_item.start_address = start_q;
		if (pos_q != 2'd0 && pfx_q != z80pd_pkg::PK_NONE && pos_q == 2'd1) begin
			if (dx.len == 3'd0) begin
				res_count = 2'd1;
				fresh = 1'b1;
			end else begin
				opc_d = in_data.code_byte;
				dd = dx;
				if (dx.len <= 3'd2) done = 1'b1;
				else begin
					rem_d = dx.len - 3'd2;
					pos_d = 2'd2;
				end
			end
		end else if (pos_q != 2'd0) begin
			wr_en = 1'b1;
			wr_idx = pos_q[0] ^ (pfx_q != z80pd_pkg::PK_NONE) ^ 1'b1;
			if (wr_idx) a1v = in_data.code_byte; else a0 = in_data.code_byte;
			pos_d = pos_q + 2'd1;
			dd = (pfx_q == z80pd_pkg::PK_NONE) ? z80pd_pkg::decode_main(opc_q)
				: z80pd_pkg::decode_ext(pfx_q, opc_q);
			if (rem_q <= 3'd1) done = 1'b1;
			else rem_d = rem_q - 3'd1;
		end else begin
			fresh = 1'b1;
		end
		if (fresh) begin
			start_d = in_data.byte_address;
			if (dm.is_prefix) begin
				pfx_d = dm.pk; opc_d = 8'h00; pos_d = 2'd1;
			end else begin
				pfx_d = z80pd_pkg::PK_NONE; opc_d = in_data.code_byte; dd = dm;
				if (dm.len <= 3'd1) done = 1'b1;
				else begin
					rem_d = dm.len - 3'd1; pos_d = 2'd1;
				end
			end
		end
		done_item = '0;
		done_item.prefix_kind = pfx_d;
		done_item.opcode = opc_d;
		done_item.length = dd.len;
		done_item.operand_form = dd.form;
		done_item.start_address = start_d;
		if (opc_d == z80pd_pkg::OP_CB &&
			(pfx_d == z80pd_pkg::PK_DD || pfx_d == z80pd_pkg::PK_FD)) begin
			done_item.opcode = a1v;
			done_item.first_operand = a0;
		end else if (dd.form == z80pd_pkg::F_IMM8 || dd.form == z80pd_pkg::F_REL8 ||
			dd.form == z80pd_pkg::F_PORT || dd.form == z80pd_pkg::F_DISP) begin
			done_item.first_operand = a0;
		end else if (dd.form == z80pd_pkg::F_IMM16 || dd.form == z80pd_pkg::F_MEM16 ||
			dd.form == z80pd_pkg::F_DIMM) begin
			done_item.first_operand = a0;
			done_item.second_operand = a1v;
		end
		if (dd.form == z80pd_pkg::F_REL8)
			done_item.branch_target = start_d + {13'd0, dd.len} + {{8{a0[7]}}, a0};
		if (done) begin
			pos_d = 2'd0; pfx_d = z80pd_pkg::PK_NONE; rem_d = 3'd0;
			res_count = res_count + 2'd1;
		end
		res0 = (res_count == 2'd2 || (res_count == 2'd1 && !done)) ? inv_item : done_item;
		res1 = done_item;
		res0.last_of_run = (res_count == 2'd1);
		res1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0; pfx_q <= 3'd0; opc_q <= 8'd0; start_q <= 16'd0; rem_q <= 3'd0;
		end else if (in_fire) begin
			pos_q <= pos_d; pfx_q <= pfx_d; opc_q <= opc_d; start_q <= start_d;
			rem_q <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && wr_en) opnd_q[wr_idx] <= in_data.code_byte;
	end
endmodule
`default_nettype wire

// ===== rtl/z80pd_queue.sv =====
// Result queue between the decode front end and the output port.
`timescale 1ns / 1ps
`default_nettype none
module z80pd_queue #(
	parameter int DEPTH = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire z80pd_pkg::out_item_t wr0,
	input  wire z80pd_pkg::out_item_t wr1,
	input  wire [1:0]              wr_count,
	output logic                   room2,
	output logic                   rd_valid,
	output z80pd_pkg::out_item_t   rd_data,
	input  wire                    rd_ready
);
	localparam int AW = $clog2(DEPTH);
	z80pd_pkg::out_item_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          pop;

	assign pop = rd_valid && rd_ready;
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign room2 = ({1'b0, cnt_q} + 2'd2) <= (AW + 2)'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q <= wp_q + AW'(wr_count);
			if (pop) rp_q <= rp_q + AW'(1);
			cnt_q <= cnt_q + (AW + 1)'(wr_count) - (AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_count != 2'd0) mem_q[wp_q] <= wr0;
		if (wr_count == 2'd2) mem_q[wp_q + AW'(1)] <= wr1;
	end
endmodule
`default_nettype wire

// ===== rtl/z80_instruction_predecoder.sv =====
// Top level: Z80 instruction predecoder, front decode plus result queue.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  in_valid/in_ready/in_data carry one code byte with its address per transaction.
//  out_valid/out_ready/out_data carry one decoded instruction per transaction.
//  A byte that completes an instruction yields one result; a byte that breaks a
//  prefix yields the invalid prefix item, then its own decode if that completes.
//  The front end decodes combinationally; a result is registered into the queue.
//  Throughput: one byte per cycle while the result queue has room for two
//  entries; the queue (DEPTH entries) is the only thing that throttles input.
//  When the receiver stalls the queue fills and in_ready drops; nothing is lost.
//  Reset clears the decode state to "awaiting first byte" and empties the queue.
module z80_instruction_predecoder #(
	parameter int DEPTH = 4
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire z80pd_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output z80pd_pkg::out_item_t      out_data
);
	z80pd_pkg::out_item_t res0, res1;
	logic [1:0] res_count, wr_count;
	logic       room2, in_fire;

	// Accept a transaction only with room for the worst case of two results.
	assign in_ready = room2;
	assign in_fire = in_valid && in_ready;
	assign wr_count = in_fire ? res_count : 2'd0;

	z80pd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .in_fire(in_fire),
		.res0(res0), .res1(res1), .res_count(res_count)
	);

	z80pd_queue #(.DEPTH(DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr0(res0), .wr1(res1), .wr_count(wr_count),
		.room2(room2), .rd_valid(out_valid), .rd_data(out_data), .rd_ready(out_ready)
	);

	// Two results only come from a broken prefix, whose first item is invalid.
	a_two_inv: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res_count == 2'd2) |-> res0.invalid)
		else $error("two results without invalid prefix item");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.length != 3'd0))
		else $error("zero length result");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped");
endmodule
`default_nettype wire

// ===== tb/tb_z80_instruction_predecoder.sv =====
// Testbench: checks the Z80 predecoder against a cycle-free decode model.
`timescale 1ns / 1ps
module tb_z80_instruction_predecoder;

	// Decode code layout: [6] prefix byte, [5:3] length, [2:0] form (or prefix kind).
	localparam logic [6:0] PFX = 7'h40;
	localparam logic [6:0] L1  = {1'b0, 3'd1, z80pd_pkg::F_IMPL};
	localparam logic [6:0] I2  = {1'b0, 3'd2, z80pd_pkg::F_IMM8};
	localparam logic [6:0] J2  = {1'b0, 3'd2, z80pd_pkg::F_REL8};
	localparam logic [6:0] P2  = {1'b0, 3'd2, z80pd_pkg::F_PORT};
	localparam logic [6:0] W3  = {1'b0, 3'd3, z80pd_pkg::F_IMM16};
	localparam logic [6:0] M3  = {1'b0, 3'd3, z80pd_pkg::F_MEM16};
	localparam logic [6:0] X2  = {1'b0, 3'd2, z80pd_pkg::F_IMPL};
	localparam logic [6:0] X4  = {1'b0, 3'd4, z80pd_pkg::F_MEM16};
	localparam logic [6:0] NO  = 7'h00;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	// Unprefixed opcodes 0x00-0x3F then 0xC0-0xFF; the middle range is all one byte.
	localparam logic [6:0] MAIN_TAB [128] = '{
		L1,W3,L1,L1,L1,L1,I2,L1,L1,L1,L1,L1,L1,L1,I2,L1,
		J2,W3,L1,L1,L1,L1,I2,L1,J2,L1,L1,L1,L1,L1,I2,L1,
		J2,W3,M3,L1,L1,L1,I2,L1,J2,L1,M3,L1,L1,L1,I2,L1,
		J2,W3,M3,L1,L1,L1,I2,L1,J2,L1,M3,L1,L1,L1,I2,L1,
		L1,L1,W3,W3,W3,L1,I2,L1,L1,L1,W3,PFX,W3,W3,I2,L1,
		L1,L1,W3,P2,W3,L1,I2,L1,L1,L1,W3,P2,W3,PFX,I2,L1,
		L1,L1,W3,L1,W3,L1,I2,L1,L1,L1,W3,L1,W3,PFX,I2,L1,
		L1,L1,W3,L1,W3,L1,I2,L1,L1,L1,W3,L1,W3,PFX,I2,L1
	};

	// ED opcodes 0x40-0x7F; zero marks an unlisted continuation.
	localparam logic [6:0] EXT_TAB [64] = '{
		X2,X2,X2,X4,X2,X2,X2,X2,X2,X2,X2,X4,NO,X2,NO,X2,
		X2,X2,X2,X4,NO,NO,X2,X2,X2,X2,X2,X4,NO,NO,X2,X2,
		X2,X2,X2,NO,NO,NO,NO,X2,X2,X2,X2,NO,NO,NO,NO,X2,
		NO,NO,X2,X4,NO,NO,NO,NO,X2,X2,X2,X4,NO,NO,NO,NO
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	z80pd_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	z80pd_pkg::out_item_t out_data;

	z80_instruction_predecoder dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #6 clk = ~clk;

	// Model state of the decoder.
	logic [1:0]  byte_pos;
	logic [2:0]  cur_prefix;
	logic [7:0]  cur_opcode;
	logic [7:0]  operand_bytes [2];
	logic [15:0] instr_start;
	logic [2:0]  bytes_left;

	z80pd_pkg::in_item_t  code_stream [$];
	z80pd_pkg::out_item_t expected_instrs [$];
	z80pd_pkg::out_item_t step_results [$];
	int  error_count = 0;
	int  quiet_cycles = 0;
	bit  steady_phase = 1'b0;
	logic [15:0] fetch_pc;

	function automatic logic [6:0] index_lookup(input logic [7:0] op);
		case (op)
			8'h09, 8'h19, 8'h29, 8'h39, 8'h23, 8'h2B,
			8'hE1, 8'hE3, 8'hE5, 8'hE9, 8'hF9: return {1'b0, 3'd2, z80pd_pkg::F_IMPL};
			8'h21: return {1'b0, 3'd4, z80pd_pkg::F_IMM16};
			8'h22, 8'h2A: return {1'b0, 3'd4, z80pd_pkg::F_MEM16};
			8'h34, 8'h35: return {1'b0, 3'd3, z80pd_pkg::F_DISP};
			8'h36: return {1'b0, 3'd4, z80pd_pkg::F_DIMM};
			8'hCB: return {1'b0, 3'd4, z80pd_pkg::F_DISP};
			default: ;
		endcase
		if (op >= 8'h70 && op <= 8'h77 && op != 8'h76)
			return {1'b0, 3'd3, z80pd_pkg::F_DISP};
		if (op >= 8'h40 && op <= 8'hBF && op[2:0] == 3'd6 && op != 8'h76)
			return {1'b0, 3'd3, z80pd_pkg::F_DISP};
		return NO;
	endfunction

	function automatic logic [6:0] lookup(input logic [2:0] pk, input logic [7:0] op);
		case (pk)
			z80pd_pkg::PK_NONE: begin
				if (op >= 8'h40 && op < 8'hC0)
					return L1;
				case (op)
					z80pd_pkg::OP_CB: return PFX | z80pd_pkg::PK_CB;
					z80pd_pkg::OP_DD: return PFX | z80pd_pkg::PK_DD;
					z80pd_pkg::OP_ED: return PFX | z80pd_pkg::PK_ED;
					z80pd_pkg::OP_FD: return PFX | z80pd_pkg::PK_FD;
					default: return MAIN_TAB[op < 8'h40 ? op : op - 8'h80];
				endcase
			end
			z80pd_pkg::PK_CB: return (op[7:3] == 5'b00110) ? NO : X2;
			z80pd_pkg::PK_ED: begin
				if (op >= 8'h40 && op < 8'h80)
					return EXT_TAB[op - 8'h40];
				return ((op & 8'hE4) == 8'hA0) ? X2 : NO;
			end
			z80pd_pkg::PK_DD, z80pd_pkg::PK_FD: return index_lookup(op);
			default: return NO;
		endcase
	endfunction

	function automatic logic [7:0] prefix_code(input logic [2:0] pk);
		case (pk)
			z80pd_pkg::PK_CB: return z80pd_pkg::OP_CB;
			z80pd_pkg::PK_DD: return z80pd_pkg::OP_DD;
			z80pd_pkg::PK_ED: return z80pd_pkg::OP_ED;
			z80pd_pkg::PK_FD: return z80pd_pkg::OP_FD;
			default: return 8'h00;
		endcase
	endfunction

	task automatic clear_decode();
		byte_pos = '0;
		cur_prefix = z80pd_pkg::PK_NONE;
		bytes_left = '0;
	endtask

	task automatic ref_reset_state();
		clear_decode();
		cur_opcode = 8'h00;
		operand_bytes[0] = 8'h00;
		operand_bytes[1] = 8'h00;
		instr_start = 16'h0000;
	endtask

	// Close the current instruction and queue its result.
	task automatic complete_instr();
		logic [6:0] c;
		z80pd_pkg::out_item_t r;
		c = lookup(cur_prefix, cur_opcode);
		r = '0;
		r.prefix_kind = cur_prefix;
		r.opcode = cur_opcode;
		r.length = c[5:3];
		r.operand_form = c[2:0];
		r.start_address = instr_start;
		if (cur_opcode == z80pd_pkg::OP_CB &&
			(cur_prefix == z80pd_pkg::PK_DD || cur_prefix == z80pd_pkg::PK_FD)) begin
			r.opcode = operand_bytes[1];
			r.first_operand = operand_bytes[0];
		end else if (c[2:0] inside {z80pd_pkg::F_IMM8, z80pd_pkg::F_REL8,
			z80pd_pkg::F_PORT, z80pd_pkg::F_DISP}) begin
			r.first_operand = operand_bytes[0];
		end else if (c[2:0] inside {z80pd_pkg::F_IMM16, z80pd_pkg::F_MEM16,
			z80pd_pkg::F_DIMM}) begin
			r.first_operand = operand_bytes[0];
			r.second_operand = operand_bytes[1];
		end
		// Relative target wraps at 64K; the displacement byte is two's complement.
		if (c[2:0] == z80pd_pkg::F_REL8)
			r.branch_target = instr_start + 16'(c[5:3]) + {{8{r.first_operand[7]}},
				r.first_operand};
		step_results.push_back(r);
		clear_decode();
	endtask

	// Advance the model by one accepted code byte.
	task automatic predict_byte(input z80pd_pkg::in_item_t it);
		logic [6:0] c;
		logic [7:0] b;
		logic [2:0] len;
		logic [1:0] slot;
		bit fresh;
		z80pd_pkg::out_item_t r;
		b = it.code_byte;
		fresh = 1'b1;
		step_results.delete();
		if (byte_pos != 0) begin
			fresh = 1'b0;
			if (cur_prefix != z80pd_pkg::PK_NONE && byte_pos == 1) begin
				c = lookup(cur_prefix, b);
				if (c == NO) begin
					// Broken prefix: report it, then decode this byte afresh.
					r = '0;
					r.prefix_kind = cur_prefix;
					r.opcode = prefix_code(cur_prefix);
					r.length = 3'd1;
					r.operand_form = z80pd_pkg::F_IMPL;
					r.invalid = 1'b1;
					r.start_address = instr_start;
					step_results.push_back(r);
					clear_decode();
					fresh = 1'b1;
				end else begin
					cur_opcode = b;
					if (c[5:3] <= 3'd2) begin
						complete_instr();
					end else begin
						bytes_left = c[5:3] - 3'd2;
						byte_pos = 2'd2;
					end
				end
			end else begin
				slot = byte_pos - 2'd1 -
					{1'b0, (cur_prefix != z80pd_pkg::PK_NONE)};
				operand_bytes[slot[0]] = b;
				byte_pos = byte_pos + 2'd1;
				if (bytes_left <= 3'd1)
					complete_instr();
				else
					bytes_left = bytes_left - 3'd1;
			end
		end
		if (fresh) begin
			instr_start = it.byte_address;
			c = lookup(z80pd_pkg::PK_NONE, b);
			if (c[6]) begin
				cur_prefix = c[2:0];
				cur_opcode = 8'h00;
				byte_pos = 2'd1;
			end else begin
				cur_prefix = z80pd_pkg::PK_NONE;
				cur_opcode = b;
				len = c[5:3];
				if (len <= 3'd1) begin
					complete_instr();
				end else begin
					bytes_left = len - 3'd1;
					byte_pos = 2'd1;
				end
			end
		end
		if (step_results.size() > 0)
			step_results[step_results.size() - 1].last_of_run = 1'b1;
		foreach (step_results[i])
			expected_instrs.push_back(step_results[i]);
	endtask

	function automatic int draw_wait();
		return steady_phase ? 0 : $urandom_range(0, 7);
	endfunction

	task automatic push_byte(input logic [7:0] b);
		z80pd_pkg::in_item_t it;
		it.code_byte = b;
		it.byte_address = fetch_pc;
		code_stream.push_back(it);
		// Mostly sequential fetch, with an occasional jump to a random address.
		fetch_pc = ($urandom_range(0, 31) == 0) ? 16'($urandom) : fetch_pc + 16'd1;
	endtask

	task automatic push_seq(input logic [7:0] bytes [$]);
		foreach (bytes[i])
			push_byte(bytes[i]);
	endtask

	task automatic report_field(input string name, input int exp_v, input int got_v);
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
		error_count++;
	endtask

	// Driver: present code bytes, with random hold-offs outside the steady phase.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				predict_byte(in_data);
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (code_stream.size() > 0) begin
				in_data <= code_stream.pop_front();
				in_valid <= 1'b1;
				send_gap = draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: accept results with random stalls outside the steady phase and compare each field.
	int recv_stall = 0;
	always @(posedge clk or negedge arst_n) begin
		z80pd_pkg::out_item_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_instrs.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual %p",
						$time, out_data);
					error_count++;
				end else begin
					e = expected_instrs.pop_front();
					if (out_data.prefix_kind !== e.prefix_kind)
						report_field("prefix_kind", e.prefix_kind, out_data.prefix_kind);
					if (out_data.opcode !== e.opcode)
						report_field("opcode", e.opcode, out_data.opcode);
					if (out_data.length !== e.length)
						report_field("length", e.length, out_data.length);
					if (out_data.operand_form !== e.operand_form)
						report_field("operand_form", e.operand_form, out_data.operand_form);
					if (out_data.first_operand !== e.first_operand)
						report_field("first_operand", e.first_operand, out_data.first_operand);
					if (out_data.second_operand !== e.second_operand)
						report_field("second_operand", e.second_operand,
							out_data.second_operand);
					if (out_data.branch_target !== e.branch_target)
						report_field("branch_target", e.branch_target, out_data.branch_target);
					if (out_data.invalid !== e.invalid)
						report_field("invalid", e.invalid, out_data.invalid);
					if (out_data.start_address !== e.start_address)
						report_field("start_address", e.start_address, out_data.start_address);
					if (out_data.last_of_run !== e.last_of_run)
						report_field("last_of_run", e.last_of_run, out_data.last_of_run);
				end
				recv_stall = draw_wait();
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_z80_instruction_predecoder: FAIL");
			$finish;
		end
	end

	initial begin
		int kind;
		logic [7:0] pfx_b;
		ref_reset_state();
		fetch_pc = 16'h0000;

		// Directed: one-byte, imm16, relative extremes, port, (nn), broken prefixes,
		// ED forms, indexed displacement and indexed CB, prefix after prefix.
		push_seq('{8'h00, 8'h01, 8'h34, 8'h12, 8'h18, 8'h80, 8'h10, 8'h7F});
		push_seq('{8'hD3, 8'hFF, 8'h22, 8'h00, 8'hFF, 8'hCB, 8'h30, 8'h00});
		push_seq('{8'hCB, 8'hFF, 8'hED, 8'h00, 8'hED, 8'h43, 8'hCD, 8'hAB});
		push_seq('{8'hED, 8'hA0, 8'hDD, 8'h36, 8'h80, 8'hFF, 8'hDD, 8'hCB});
		push_seq('{8'h80, 8'h06, 8'hFD, 8'h34, 8'h7F, 8'hDD, 8'hDD, 8'h21});
		push_seq('{8'h01, 8'h02, 8'hFD, 8'hED, 8'h79, 8'hFF});
		fetch_pc = 16'hFFFE;
		push_seq('{8'h20, 8'h7F, 8'h38, 8'h80});

		// Random: prefixed sequences with random content, plus raw noise in equal share.
		while (code_stream.size() < 1800) begin
			kind = $urandom_range(0, 9);
			case ($urandom_range(0, 3))
				0: pfx_b = z80pd_pkg::OP_CB;
				1: pfx_b = z80pd_pkg::OP_DD;
				2: pfx_b = z80pd_pkg::OP_ED;
				default: pfx_b = z80pd_pkg::OP_FD;
			endcase
			if (kind < 3) begin
				push_byte(pfx_b);
				push_byte(8'($urandom));
			end else if (kind == 3) begin
				push_byte($urandom_range(0, 1) ? z80pd_pkg::OP_DD : z80pd_pkg::OP_FD);
				push_byte(z80pd_pkg::OP_CB);
				push_byte(8'($urandom));
				push_byte(8'($urandom));
			end else if (kind == 4) begin
				push_byte(z80pd_pkg::OP_ED);
				push_byte(8'($urandom_range(8'h40, 8'h7F)));
			end else begin
				push_byte(8'($urandom));
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Alternate stretches with and without idling.
		while (code_stream.size() > 0 || in_valid || expected_instrs.size() > 0) begin
			repeat (150) begin
				@(posedge clk);
			end
			steady_phase = ~steady_phase;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && expected_instrs.size() == 0)
			$display("tb_z80_instruction_predecoder: PASS");
		else
			$display("tb_z80_instruction_predecoder: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/z80pd_pkg.sv
rtl/z80pd_front.sv
rtl/z80pd_queue.sv
rtl/z80_instruction_predecoder.sv
tb/tb_z80_instruction_predecoder.sv
